// ===== design/pksf_pkg.sv =====
// ============================================================================
// pksf_pkg
// Shared types, constants and register codes of the port knock subnet filter.
// ============================================================================
package pksf_pkg;

    // Header capture window and byte counter
    localparam int HEADER_BYTES   = 96;
    localparam int CNT_W          = 7;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Subnet bitmap geometry: one byte row of 8 bits per 8 subnets
    localparam int PREFIX_ENTRIES = 65536;
    localparam int ROW_SEL_W      = 5;
    localparam int BM_AW          = $clog2(PREFIX_ENTRIES) + ROW_SEL_W;
    localparam int BM_DEPTH       = PREFIX_ENTRIES * (2 ** ROW_SEL_W);
    localparam logic [BM_AW-1:0] BM_LAST = BM_AW'(BM_DEPTH - 1);

    // Fixed header byte positions (Ethernet + IPv4)
    localparam int POS_ETYPE  = 12;
    localparam int POS_IHL    = 14;
    localparam int POS_PROTO  = 23;
    localparam int POS_SRC    = 26;
    localparam int POS_SRC_C  = 28;
    localparam int POS_DST    = 30;
    localparam int L4_BASE    = 14;

    // Positions relative to the start of the L4 header
    localparam int REL_PORT   = 2;
    localparam int REL_ULEN   = 4;
    localparam int REL_PAY    = 8;
    localparam int REL_FLAGS  = 13;

    // Length limits
    localparam int MIN_IPV4   = 34;
    localparam int UDP_HDR    = 8;
    localparam int KNOCK_END  = 10;
    localparam int TCP_HDR    = 20;

    // Protocol codes and flag bits
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam int          FLAG_SYN   = 1;
    localparam int          FLAG_ACK   = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SERVER_PREFIX  = 3'd0,
        CFG_KNOCK_PORT_LO  = 3'd1,
        CFG_KNOCK_PORT_HI  = 3'd2,
        CFG_KNOCK_UDP_LEN  = 3'd3,
        CFG_GUARDED_PORT   = 3'd4
    } t_cfg_idx;

    localparam logic [15:0] RST_SERVER_PREFIX = 16'h0A01;
    localparam logic [15:0] RST_KNOCK_PORT_LO = 16'd1000;
    localparam logic [15:0] RST_KNOCK_PORT_HI = 16'd2000;
    localparam logic [15:0] RST_KNOCK_UDP_LEN = 16'd10;
    localparam logic [15:0] RST_GUARDED_PORT  = 16'd443;

    typedef struct packed {
        logic [15:0] server_prefix;
        logic [15:0] knock_port_low;
        logic [15:0] knock_port_high;
        logic [15:0] knock_udp_length;
        logic [15:0] guarded_tcp_port;
    } t_cfg;

    // Header fields of one frame, plus its saturated length
    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic [15:0]      etype;
        logic [3:0]       ihl;
        logic [7:0]       proto;
        logic [15:0]      src_key;
        logic [7:0]       src_c;
        logic [15:0]      dst_hi;
        logic [15:0]      l4_port;
        logic [15:0]      udp_len;
        logic [15:0]      payload;
        logic [7:0]       tcp_flags;
    } t_frame;

    // Per-frame decision before the bitmap lookup
    typedef struct packed {
        logic             verdict;
        logic             syn_check;
        logic             knock;
        logic [BM_AW-1:0] bm_addr;
        logic [2:0]       bm_bit;
    } t_decide;

    // Bitmap access request
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [BM_AW-1:0] addr;
        logic [2:0]       bit_sel;
    } t_bm_req;

endpackage

// ===== design/pksf_capture.sv =====
// ============================================================================
// pksf_capture
// Byte counter and on-the-fly capture of the header fields of one frame.
// ============================================================================
module pksf_capture (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_frame_byte,
    input  logic                  i_frame_end,
    output pksf_pkg::t_frame      o_frame
);

    logic [pksf_pkg::CNT_W-1:0] r_cnt;
    logic [pksf_pkg::CNT_W-1:0] n_cnt;
    pksf_pkg::t_frame           r_hdr;
    pksf_pkg::t_frame           n_hdr;
    logic [pksf_pkg::CNT_W-1:0] off;
    logic [pksf_pkg::CNT_W-1:0] rel;
    logic                       in_store;
    logic                       l4_hit;

    // Place each beat into the header fields it belongs to
    always_comb begin
        n_hdr    = r_hdr;
        in_store = {1'b0, r_cnt} < 8'(pksf_pkg::HEADER_BYTES);
        off      = pksf_pkg::CNT_W'(pksf_pkg::L4_BASE) + {1'b0, r_hdr.ihl, 2'b00};
        l4_hit   = in_store && (r_cnt >= off);
        rel      = r_cnt - off;

        if (in_store) begin
            case (r_cnt)
                pksf_pkg::CNT_W'(pksf_pkg::POS_ETYPE):     n_hdr.etype[15:8]  = i_frame_byte;
                pksf_pkg::CNT_W'(pksf_pkg::POS_ETYPE + 1): n_hdr.etype[7:0]   = i_frame_byte;
                pksf_pkg::CNT_W'(pksf_pkg::POS_IHL):       n_hdr.ihl = i_frame_byte[3:0];
                pksf_pkg::CNT_W'(pksf_pkg::POS_PROTO):     n_hdr.proto = i_frame_byte;
                pksf_pkg::CNT_W'(pksf_pkg::POS_SRC):       n_hdr.src_key[15:8] = i_frame_byte;
                pksf_pkg::CNT_W'(pksf_pkg::POS_SRC + 1):   n_hdr.src_key[7:0]  = i_frame_byte;
                pksf_pkg::CNT_W'(pksf_pkg::POS_SRC_C):     n_hdr.src_c = i_frame_byte;
                pksf_pkg::CNT_W'(pksf_pkg::POS_DST):       n_hdr.dst_hi[15:8] = i_frame_byte;
                pksf_pkg::CNT_W'(pksf_pkg::POS_DST + 1):   n_hdr.dst_hi[7:0]  = i_frame_byte;
                default: ;
            endcase
        end

        // L4 fields; a short IHL lets them overlap the IP header
        if (l4_hit) begin
            case (rel)
                pksf_pkg::CNT_W'(pksf_pkg::REL_PORT):     n_hdr.l4_port[15:8] = i_frame_byte;
                pksf_pkg::CNT_W'(pksf_pkg::REL_PORT + 1): n_hdr.l4_port[7:0]  = i_frame_byte;
                pksf_pkg::CNT_W'(pksf_pkg::REL_ULEN):     n_hdr.udp_len[15:8] = i_frame_byte;
                pksf_pkg::CNT_W'(pksf_pkg::REL_ULEN + 1): n_hdr.udp_len[7:0]  = i_frame_byte;
                pksf_pkg::CNT_W'(pksf_pkg::REL_PAY):      n_hdr.payload[15:8] = i_frame_byte;
                pksf_pkg::CNT_W'(pksf_pkg::REL_PAY + 1):  n_hdr.payload[7:0]  = i_frame_byte;
                pksf_pkg::CNT_W'(pksf_pkg::REL_FLAGS):    n_hdr.tcp_flags = i_frame_byte;
                default: ;
            endcase
        end

        // Saturate the length
        n_cnt       = (r_cnt == pksf_pkg::COUNT_MAX) ? r_cnt : r_cnt + 1'b1;
        n_hdr.len   = n_cnt;
        o_frame     = n_hdr;
    end

    // Hold captured fields; they are only read up to the frame length
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hdr <= n_hdr;
        end
    end

    // Advance the byte counter, restart on the final beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_accept) begin
            r_cnt <= i_frame_end ? '0 : n_cnt;
        end
    end

endmodule

// ===== design/pksf_judge.sv =====
// ============================================================================
// pksf_judge
// Classifies one completed frame and forms its bitmap address.
// ============================================================================
module pksf_judge (
    input  pksf_pkg::t_frame  i_frame,
    input  pksf_pkg::t_cfg    i_cfg,
    output pksf_pkg::t_decide o_decide
);

    logic [pksf_pkg::CNT_W-1:0] off;
    logic [pksf_pkg::CNT_W:0]   len_x;
    logic                       udp_fit;
    logic                       pay_fit;
    logic                       tcp_fit;
    logic                       to_server;
    logic                       port_in;
    logic                       is_ipv4;

    always_comb begin
        off     = pksf_pkg::CNT_W'(pksf_pkg::L4_BASE) + {1'b0, i_frame.ihl, 2'b00};
        len_x   = {1'b0, i_frame.len};
        udp_fit = ({1'b0, off} + (pksf_pkg::CNT_W+1)'(pksf_pkg::UDP_HDR))   <= len_x;
        pay_fit = ({1'b0, off} + (pksf_pkg::CNT_W+1)'(pksf_pkg::KNOCK_END)) <= len_x;
        tcp_fit = ({1'b0, off} + (pksf_pkg::CNT_W+1)'(pksf_pkg::TCP_HDR))   <= len_x;

        to_server = (i_frame.dst_hi == i_cfg.server_prefix);
        port_in   = (i_frame.l4_port >= i_cfg.knock_port_low) &&
                    (i_frame.l4_port <= i_cfg.knock_port_high);
        is_ipv4   = (i_frame.len >= pksf_pkg::CNT_W'(pksf_pkg::MIN_IPV4)) &&
                    (i_frame.etype == pksf_pkg::ETYPE_IPV4);

        o_decide         = '0;
        o_decide.bm_addr = {i_frame.src_key, i_frame.src_c[7:8-pksf_pkg::ROW_SEL_W]};
        o_decide.bm_bit  = i_frame.src_c[2:0];

        if (is_ipv4) begin
            if (i_frame.proto == pksf_pkg::PROTO_UDP) begin
                // Drop knock-range UDP to the server; record a well-formed knock
                if (udp_fit && port_in && to_server) begin
                    o_decide.verdict = 1'b1;
                    o_decide.knock   = (i_frame.udp_len == i_cfg.knock_udp_length) &&
                                       pay_fit && (i_frame.payload == i_frame.l4_port);
                end
            end else if (i_frame.proto == pksf_pkg::PROTO_TCP) begin
                // Cut-off TCP header drops; a guarded SYN waits for the bitmap
                if (!tcp_fit) begin
                    o_decide.verdict = 1'b1;
                end else begin
                    o_decide.syn_check = i_frame.tcp_flags[pksf_pkg::FLAG_SYN] &&
                                         !i_frame.tcp_flags[pksf_pkg::FLAG_ACK] &&
                                         (i_frame.l4_port == i_cfg.guarded_tcp_port) &&
                                         to_server;
                end
            end
        end
    end

endmodule

// ===== design/pksf_bitmap.sv =====
// ============================================================================
// pksf_bitmap
// Subnet bitmap memory with bit-enable set, registered read and a clearing
// pass after reset.
// ============================================================================
module pksf_bitmap (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pksf_pkg::t_bm_req i_req,
    output logic [7:0]        o_rd_data,
    output logic              o_busy
);

    logic [7:0]                 r_mem [0:pksf_pkg::BM_DEPTH-1];
    logic [7:0]                 r_rd;
    logic                       r_busy;
    logic [pksf_pkg::BM_AW-1:0] r_clr_addr;

    // Sweep every row to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == pksf_pkg::BM_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Write port: clear a row, or set one subnet bit
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.addr][i_req.bit_sel] <= 1'b1;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd;
    assign o_busy    = r_busy;

endmodule

// ===== design/port_knock_subnet_filter_core.sv =====
// ============================================================================
// port_knock_subnet_filter_core
// Per-frame pass/drop filter with UDP port knocking and a /24 subnet bitmap.
// ============================================================================
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+--------------------------
//  in      | sink      | i_in_valid / o_in_stall     | i_frame_byte, i_frame_end
//  out     | source    | o_out_valid / i_out_stall   | o_verdict, o_knock_recorded
//  cfg     | sink      | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One frame byte is taken every cycle unless the input is stalled. The
// verdict of a frame passes three registers after its final beat: frame
// record, decision plus bitmap read, output. The bitmap's read and write
// ports serve one frame per cycle while the decision stage can take it.
// After reset the bitmap clearing pass sweeps all 2,097,152 rows with the
// input stalled; configuration writes are taken throughout. Beyond that, the
// input stalls only when frame record, decision and output stages are all full and the output is stalled.
// ============================================================================
module port_knock_subnet_filter_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input beats
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_frame_byte,
    input  logic                            i_frame_end,
    // result beats
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_verdict,
    output logic                            o_knock_recorded,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pksf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pksf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    pksf_pkg::t_cfg    r_cfg;
    pksf_pkg::t_frame  cap_frame;
    pksf_pkg::t_frame  r_f;
    logic              r_f_vld;
    pksf_pkg::t_decide dec;
    pksf_pkg::t_decide r_s;
    logic              r_s_vld;
    logic              r_o_vld;
    logic              r_o_verdict;
    logic              r_o_knock;
    pksf_pkg::t_bm_req bm_req;
    logic [7:0]        bm_rd;
    logic              bm_busy;
    logic              in_accept;
    logic              o_load;
    logic              s_ready;
    logic              s_load;
    logic              f_load;

    // Pipeline flow control
    always_comb begin
        o_load     = r_s_vld && (!r_o_vld || !i_out_stall);
        s_ready    = !r_s_vld || o_load;
        s_load     = r_f_vld && s_ready;
        o_in_stall = bm_busy || (r_f_vld && !s_ready);
        in_accept  = i_in_valid && !o_in_stall;
        f_load     = in_accept && i_frame_end;
    end

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.server_prefix    <= pksf_pkg::RST_SERVER_PREFIX;
            r_cfg.knock_port_low   <= pksf_pkg::RST_KNOCK_PORT_LO;
            r_cfg.knock_port_high  <= pksf_pkg::RST_KNOCK_PORT_HI;
            r_cfg.knock_udp_length <= pksf_pkg::RST_KNOCK_UDP_LEN;
            r_cfg.guarded_tcp_port <= pksf_pkg::RST_GUARDED_PORT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (pksf_pkg::t_cfg_idx'(i_cfg_index))
                pksf_pkg::CFG_SERVER_PREFIX: r_cfg.server_prefix    <= i_cfg_data;
                pksf_pkg::CFG_KNOCK_PORT_LO: r_cfg.knock_port_low   <= i_cfg_data;
                pksf_pkg::CFG_KNOCK_PORT_HI: r_cfg.knock_port_high  <= i_cfg_data;
                pksf_pkg::CFG_KNOCK_UDP_LEN: r_cfg.knock_udp_length <= i_cfg_data;
                pksf_pkg::CFG_GUARDED_PORT:  r_cfg.guarded_tcp_port <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Header capture
    pksf_capture u_capture (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_frame_byte (i_frame_byte),
        .i_frame_end  (i_frame_end),
        .o_frame      (cap_frame)
    );

    // Frame record stage: hold the finished frame's fields
    always_ff @(posedge i_clk) begin
        if (f_load) begin
            r_f <= cap_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (f_load) begin
            r_f_vld <= 1'b1;
        end else if (s_load) begin
            r_f_vld <= 1'b0;
        end
    end

    // Classification
    pksf_judge u_judge (
        .i_frame  (r_f),
        .i_cfg    (r_cfg),
        .o_decide (dec)
    );

    // Bitmap access as the frame moves into the decision stage
    always_comb begin
        bm_req.rd_en   = s_load;
        bm_req.wr_en   = s_load && dec.knock;
        bm_req.addr    = dec.bm_addr;
        bm_req.bit_sel = dec.bm_bit;
    end

    pksf_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (bm_req),
        .o_rd_data (bm_rd),
        .o_busy    (bm_busy)
    );

    // Decision stage
    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_s <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (s_load) begin
            r_s_vld <= 1'b1;
        end else if (o_load) begin
            r_s_vld <= 1'b0;
        end
    end

    // Output stage: a guarded SYN drops unless its subnet bit is set
    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_o_verdict <= r_s.syn_check ? !bm_rd[r_s.bm_bit] : r_s.verdict;
            r_o_knock   <= r_s.knock;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (o_load) begin
            r_o_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    assign o_out_valid      = r_o_vld;
    assign o_verdict        = r_o_verdict;
    assign o_knock_recorded = r_o_knock;

endmodule
